// ===== rtl/core/tcgw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_pkg
// Types, register codes and reset values shared by the glyph writer modules.
// ----------------------------------------------------------------------------
package tcgw_pkg;

  localparam int unsigned COORD_W     = 12;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned ROW_W       = 4;
  localparam int unsigned BITS_W      = 8;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned ADDR_W      = 33;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned STORE_AW    = CODE_W + ROW_W;

  localparam int unsigned DEF_GLYPH_WIDTH  = 8;
  localparam int unsigned DEF_GLYPH_HEIGHT = 16;
  localparam int unsigned DEF_QUEUE_DEPTH  = 2;

  localparam logic [COORD_W-1:0] COORD_MAX  = '1;
  localparam logic [CODE_W-1:0]  SPACE_CODE = 8'h20;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FB_BASE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR      = 3'd6;

  typedef enum logic [1:0] {
    KIND_DRAW    = 2'd0,
    KIND_ERASE   = 2'd1,
    KIND_NEWLINE = 2'd2,
    KIND_LOAD    = 2'd3
  } kind_e;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef struct packed {
    logic [31:0]        fb_base;
    logic [15:0]        row_pitch;
    logic [2:0]         bytes_per_pixel;
    logic [COORD_W-1:0] screen_width;
    logic [COORD_W-1:0] screen_height;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fb_base:         32'd0,
    row_pitch:       16'd3072,
    bytes_per_pixel: 3'd3,
    screen_width:    12'd1024,
    screen_height:   12'd768,
    fg_color:        24'hFFFFFF,
    bg_color:        24'h000000
  };

  // One queued command: a glyph to draw at a cell, or one font row to store.
  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CODE_W-1:0]  code;
    logic [ROW_W-1:0]   row;
    logic [BITS_W-1:0]  bits;
  } cmd_t;

endpackage

// ===== rtl/core/tcgw_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_in_if
// Input channel: console items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcgw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  logic [3:0] font_row;
  logic [7:0] font_bits;

  modport source (output valid, output kind, output char_code, output font_row,
                  output font_bits, input ready);
  modport sink (input valid, input kind, input char_code, input font_row,
                input font_bits, output ready);
endinterface

// ===== rtl/core/tcgw_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_out_if
// Output channel: one framebuffer row write per transfer.
// ----------------------------------------------------------------------------
interface tcgw_out_if;
  logic        valid;
  logic        ready;
  logic [32:0] row_address;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  glyph_bits;
  logic [23:0] ink_color;
  logic [23:0] paper_color;
  logic        off_screen;
  logic        last;

  modport source (output valid, output row_address, output pixel_x, output pixel_y,
                  output glyph_bits, output ink_color, output paper_color,
                  output off_screen, output last, input ready);
  modport sink (input valid, input row_address, input pixel_x, input pixel_y,
                input glyph_bits, input ink_color, input paper_color,
                input off_screen, input last, output ready);
endinterface

// ===== rtl/core/tcgw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_front
// Accepts console items, keeps the text cursor and queues draw and load work.
// ----------------------------------------------------------------------------
module tcgw_front #(
  parameter int unsigned GLYPH_WIDTH  = tcgw_pkg::DEF_GLYPH_WIDTH,
  parameter int unsigned GLYPH_HEIGHT = tcgw_pkg::DEF_GLYPH_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcgw_pkg::cfg_t   cfg_i,
  tcgw_in_if.sink          in_ch,
  input  logic             full_i,
  output logic             push_o,
  output tcgw_pkg::cmd_t   cmd_o
);
  import tcgw_pkg::*;

  localparam logic [COORD_W:0] GW = (COORD_W+1)'(GLYPH_WIDTH);
  localparam logic [COORD_W:0] GH = (COORD_W+1)'(GLYPH_HEIGHT);

  logic [COORD_W-1:0] cursor_x_q, cursor_x_d;
  logic [COORD_W-1:0] cursor_y_q, cursor_y_d;

  logic               accept;
  logic               at_origin;
  logic [COORD_W-1:0] sx, sy;
  logic [COORD_W-1:0] dx, dy;
  logic               wrap;

  function automatic logic [COORD_W-1:0] move_down(input logic [COORD_W-1:0] y);
    logic [COORD_W:0] n;
    n = {1'b0, y} + GH;
    return (n > {1'b0, COORD_MAX}) ? COORD_MAX : n[COORD_W-1:0];
  endfunction

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && !full_i;
  assign at_origin   = (cursor_x_q == '0) && (cursor_y_q == '0);

  // Start cell of the glyph: the cursor for a draw, one cell back for an erase.
  always_comb begin
    sx = cursor_x_q;
    sy = cursor_y_q;
    if (in_ch.kind == KIND_ERASE) begin
      if (cursor_x_q == '0) begin
        sy = ({1'b0, cursor_y_q} > GH) ? COORD_W'({1'b0, cursor_y_q} - GH) : '0;
        sx = ({1'b0, cfg_i.screen_width} > GW)
           ? COORD_W'({1'b0, cfg_i.screen_width} - GW) : '0;
      end else begin
        sx = ({1'b0, cursor_x_q} > GW) ? COORD_W'({1'b0, cursor_x_q} - GW) : '0;
      end
    end
  end

  assign wrap = ({1'b0, sx} + GW - (COORD_W+1)'(1)) >= {1'b0, cfg_i.screen_width};
  assign dx   = wrap ? '0 : sx;
  assign dy   = wrap ? move_down(sy) : sy;

  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    push_o     = 1'b0;
    cmd_o      = '{op: OP_DRAW, x: dx, y: dy, code: in_ch.char_code,
                   row: in_ch.font_row, bits: in_ch.font_bits};
    if (accept) begin
      case (in_ch.kind)
        KIND_DRAW: begin
          push_o     = 1'b1;
          cursor_x_d = COORD_W'({1'b0, dx} + GW);
          cursor_y_d = dy;
        end
        KIND_ERASE: begin
          if (!at_origin) begin
            push_o     = 1'b1;
            cmd_o.code = SPACE_CODE;
            cursor_x_d = dx;
            cursor_y_d = dy;
          end
        end
        KIND_NEWLINE: begin
          cursor_x_d = '0;
          cursor_y_d = move_down(cursor_y_q);
        end
        KIND_LOAD: begin
          push_o   = 1'b1;
          cmd_o.op = OP_LOAD;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

  // A drawn glyph always leaves the cursor one cell right of where it went.
  a_draw_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_ch.kind == KIND_DRAW)
    |=> cursor_x_q == COORD_W'({1'b0, $past(dx)} + GW))
    else $error("cursor did not advance after a draw");

  // Nothing is queued while the queue is full.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !push_o)
    else $error("push into a full queue");

endmodule

// ===== rtl/core/tcgw_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tcgw_fifo #(
  parameter int unsigned DEPTH = tcgw_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcgw_pkg::cmd_t data_i,
  input  logic           pop_i,
  output tcgw_pkg::cmd_t data_o,
  output logic           empty_o,
  output logic           full_o
);
  import tcgw_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t             entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule

// ===== rtl/core/tcgw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_back
// Glyph store and row sequencer: stores font rows and emits one framebuffer
// row write per glyph row through a three-stage pipeline.
// ----------------------------------------------------------------------------
module tcgw_back #(
  parameter int unsigned GLYPH_WIDTH  = tcgw_pkg::DEF_GLYPH_WIDTH,
  parameter int unsigned GLYPH_HEIGHT = tcgw_pkg::DEF_GLYPH_HEIGHT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcgw_pkg::cfg_t cfg_i,
  input  tcgw_pkg::cmd_t cmd_i,
  input  logic           empty_i,
  output logic           pop_o,
  tcgw_out_if.source     out_ch
);
  import tcgw_pkg::*;

  localparam int unsigned PITCH_PROD_W = 16 + COORD_W;
  localparam int unsigned BPP_PROD_W   = 3 + COORD_W;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);
  localparam int unsigned BIT_SHIFT = BITS_W - GLYPH_WIDTH;

  logic [BITS_W-1:0] glyph_mem [STORE_DEPTH];

  cmd_t             cmd_q;
  logic             active_q;
  logic [ROW_W-1:0] row_q;
  logic             adv, issue, last_row, cmd_free, is_load;

  // Stage 1: row coordinates and store read.
  logic               v1_q;
  logic [COORD_W-1:0] x1_q, y1_q;
  logic               off1_q, last1_q;
  logic [BITS_W-1:0]  rd_q;
  logic [COORD_W:0]   y_sum;
  logic [COORD_W-1:0] y_cap;
  logic               off_row;

  // Stage 2: products.
  logic                    v2_q;
  logic [PITCH_PROD_W-1:0] p_pitch_q;
  logic [BPP_PROD_W-1:0]   p_bpp_q;
  logic [COORD_W-1:0]      x2_q, y2_q;
  logic                    off2_q, last2_q;
  logic [BITS_W-1:0]       bits2_q;

  // Output register.
  logic               ov_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [COORD_W-1:0] ox_q, oy_q;
  logic [BITS_W-1:0]  obits_q;
  logic [COLOR_W-1:0] ink_q, paper_q;
  logic               ooff_q, olast_q;

  assign adv      = !ov_q || out_ch.ready;
  assign is_load  = active_q && (cmd_q.op == OP_LOAD);
  assign issue    = active_q && (cmd_q.op == OP_DRAW) && adv;
  assign last_row = (row_q == LAST_ROW);
  assign cmd_free = !active_q || is_load || (issue && last_row);
  assign pop_o    = cmd_free && !empty_i;

  // Rows past the coordinate range are clamped to the last line and flagged.
  assign y_sum   = {1'b0, cmd_q.y} + (COORD_W+1)'(row_q);
  assign y_cap   = y_sum[COORD_W] ? COORD_MAX : y_sum[COORD_W-1:0];
  assign off_row = y_sum[COORD_W] || (y_cap >= cfg_i.screen_height);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      row_q    <= '0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        row_q    <= '0;
      end else begin
        if (cmd_free) begin
          active_q <= 1'b0;
        end
        if (issue && !last_row) begin
          row_q <= row_q + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_load) begin
      glyph_mem[{cmd_q.code, cmd_q.row}] <= cmd_q.bits;
    end
    if (issue) begin
      rd_q <= glyph_mem[{cmd_q.code, row_q}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= issue;
      v2_q <= v1_q;
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      x1_q    <= cmd_q.x;
      y1_q    <= y_cap;
      off1_q  <= off_row;
      last1_q <= last_row;
    end
    if (adv && v1_q) begin
      p_pitch_q <= PITCH_PROD_W'(cfg_i.row_pitch) * PITCH_PROD_W'(y1_q);
      p_bpp_q   <= BPP_PROD_W'(cfg_i.bytes_per_pixel) * BPP_PROD_W'(x1_q);
      x2_q      <= x1_q;
      y2_q      <= y1_q;
      off2_q    <= off1_q;
      last2_q   <= last1_q;
      bits2_q   <= BITS_W'(rd_q << BIT_SHIFT);
    end
    if (adv && v2_q) begin
      addr_q  <= ADDR_W'(cfg_i.fb_base) + ADDR_W'(p_pitch_q) + ADDR_W'(p_bpp_q);
      ox_q    <= x2_q;
      oy_q    <= y2_q;
      obits_q <= bits2_q;
      ink_q   <= cfg_i.fg_color;
      paper_q <= cfg_i.bg_color;
      ooff_q  <= off2_q;
      olast_q <= last2_q;
    end
  end

  assign out_ch.valid       = ov_q;
  assign out_ch.row_address = addr_q;
  assign out_ch.pixel_x     = ox_q;
  assign out_ch.pixel_y     = oy_q;
  assign out_ch.glyph_bits  = obits_q;
  assign out_ch.ink_color   = ink_q;
  assign out_ch.paper_color = paper_q;
  assign out_ch.off_screen  = ooff_q;
  assign out_ch.last        = olast_q;

  a_stage_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && adv |=> v2_q)
    else $error("row lost between pipeline stages");

  a_last_row_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && last_row |=> !active_q || (row_q == '0))
    else $error("sequencer kept counting past the final row");

endmodule

// ===== rtl/core/text_console_glyph_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_writer
// Bitmap-font text console: cursor handling, glyph store and row writes.
// ----------------------------------------------------------------------------
// A draw or erase item produces GLYPH_HEIGHT row writes, one per clock while
// the output channel is not stalled, in the back end's row sequencer, which
// reads one glyph row from the store's single read port each cycle; the first
// write passes stage 1, stage 2 and the output register. A font load is only
// stored, and a newline or an erase at the origin is finished in the front end
// on the cycle of its transfer. The front end accepts items while the command
// queue has room, so cursor updates run ahead of the row writes. The glyph
// store is not cleared after reset; rows must be loaded before they are drawn.
// Configuration must only be written while no item is in flight.
module text_console_glyph_writer #(
  parameter int unsigned GLYPH_WIDTH  = tcgw_pkg::DEF_GLYPH_WIDTH,
  parameter int unsigned GLYPH_HEIGHT = tcgw_pkg::DEF_GLYPH_HEIGHT,
  parameter int unsigned QUEUE_DEPTH  = tcgw_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tcgw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tcgw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  tcgw_in_if.sink                           in_ch,
  tcgw_out_if.source                        out_ch
);
  import tcgw_pkg::*;

  cfg_t cfg_q;
  cmd_t push_cmd, pop_cmd;
  logic push, pop, empty, full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FB_BASE:       cfg_q.fb_base         <= cfg_data_i;
        CFG_ROW_PITCH:     cfg_q.row_pitch       <= cfg_data_i[15:0];
        CFG_BYTES_PER_PIX: cfg_q.bytes_per_pixel <= cfg_data_i[2:0];
        CFG_SCREEN_WIDTH:  cfg_q.screen_width    <= cfg_data_i[COORD_W-1:0];
        CFG_SCREEN_HEIGHT: cfg_q.screen_height   <= cfg_data_i[COORD_W-1:0];
        CFG_FG_COLOR:      cfg_q.fg_color        <= cfg_data_i[COLOR_W-1:0];
        CFG_BG_COLOR:      cfg_q.bg_color        <= cfg_data_i[COLOR_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  tcgw_front #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_ch  (in_ch),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  tcgw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  tcgw_back #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .cmd_i   (pop_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== verif/tcgw_row_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_row_checker
// Follows the configuration writes and every accepted console item, keeps its
// own cursor and font store, and compares each framebuffer row write of the
// glyph writer with the row it predicts, in order of arrival.
// ----------------------------------------------------------------------------
module tcgw_row_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcgw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcgw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tcgw_in_if                              item_ch,
  tcgw_out_if                             row_ch,
  output int unsigned                     mismatch_count,
  output int unsigned                     rows_pending
);
  import tcgw_pkg::*;

  localparam int unsigned GW           = DEF_GLYPH_WIDTH;
  localparam int unsigned GH           = DEF_GLYPH_HEIGHT;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ADDR_W-1:0]  row_address;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [BITS_W-1:0]  glyph_bits;
    logic [COLOR_W-1:0] ink_color;
    logic [COLOR_W-1:0] paper_color;
    logic               off_screen;
    logic               last;
  } row_write_t;

  cfg_t               regs;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [BITS_W-1:0]  font_rows [STORE_DEPTH];
  row_write_t         rows_due [$];

  function automatic logic [COORD_W-1:0] line_below(input logic [COORD_W-1:0] y);
    int unsigned n;
    n = 32'(y) + GH;
    return (n > 32'(COORD_MAX)) ? COORD_MAX : COORD_W'(n);
  endfunction

  // Wraps first if the cell would cross the right edge, then queues one write
  // per glyph row and moves the cursor one cell on.
  task automatic paint_cell(input logic [CODE_W-1:0] code);
    int unsigned       y;
    logic              off;
    logic [63:0]       addr;
    logic [BITS_W-1:0] stored;
    row_write_t        w;
    if (32'(cur_x) + GW - 1 >= 32'(regs.screen_width)) begin
      cur_y = line_below(cur_y);
      cur_x = '0;
    end
    for (int unsigned i = 0; i < GH; i++) begin
      y = 32'(cur_y) + i;
      off = 1'b0;
      // Rows past the last coordinate are pinned to it and always off-screen.
      if (y > 32'(COORD_MAX)) begin
        y = 32'(COORD_MAX);
        off = 1'b1;
      end
      if (y >= 32'(regs.screen_height)) off = 1'b1;
      stored = font_rows[{code, ROW_W'(i)}];
      addr = 64'(regs.fb_base) + 64'(regs.row_pitch) * 64'(y)
           + 64'(regs.bytes_per_pixel) * 64'(cur_x);
      w.row_address = addr[ADDR_W-1:0];
      w.pixel_x     = cur_x;
      w.pixel_y     = COORD_W'(y);
      w.glyph_bits  = BITS_W'(stored << (BITS_W - GW));
      w.ink_color   = regs.fg_color;
      w.paper_color = regs.bg_color;
      w.off_screen  = off;
      w.last        = (i == GH - 1);
      rows_due.push_back(w);
    end
    cur_x = cur_x + COORD_W'(GW);
  endtask

  task automatic step_back();
    if (cur_x == '0) begin
      if (cur_y == '0) return;
      cur_y = (cur_y > GH) ? cur_y - COORD_W'(GH) : '0;
      cur_x = (regs.screen_width > GW) ? regs.screen_width - COORD_W'(GW) : '0;
    end else begin
      cur_x = (cur_x > GW) ? cur_x - COORD_W'(GW) : '0;
    end
    paint_cell(SPACE_CODE);
    // The space may have wrapped; the cursor stays on the cell it painted.
    cur_x = cur_x - COORD_W'(GW);
  endtask

  task automatic show_row(input string tag, input row_write_t w);
    $display("%0t %s addr=%h x=%0d y=%0d bits=%h ink=%h paper=%h off=%b last=%b",
             $time, tag, w.row_address, w.pixel_x, w.pixel_y, w.glyph_bits,
             w.ink_color, w.paper_color, w.off_screen, w.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    row_write_t seen;
    row_write_t due;
    if (!rst_ni) begin
      regs = CFG_RESET;
      cur_x = '0;
      cur_y = '0;
      rows_due.delete();
      mismatch_count = 0;
    end else begin
      if (row_ch.valid && row_ch.ready) begin
        seen.row_address = row_ch.row_address;
        seen.pixel_x     = row_ch.pixel_x;
        seen.pixel_y     = row_ch.pixel_y;
        seen.glyph_bits  = row_ch.glyph_bits;
        seen.ink_color   = row_ch.ink_color;
        seen.paper_color = row_ch.paper_color;
        seen.off_screen  = row_ch.off_screen;
        seen.last        = row_ch.last;
        if (rows_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("ERROR: row write transfer with no row predicted");
            show_row("  got     ", seen);
          end
        end else begin
          due = rows_due.pop_front();
          if (seen !== due) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("ERROR: row write differs from the predicted row");
              show_row("  expected", due);
              show_row("  got     ", seen);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FB_BASE:       regs.fb_base = cfg_data_i;
          CFG_ROW_PITCH:     regs.row_pitch = cfg_data_i[15:0];
          CFG_BYTES_PER_PIX: regs.bytes_per_pixel = cfg_data_i[2:0];
          CFG_SCREEN_WIDTH:  regs.screen_width = cfg_data_i[COORD_W-1:0];
          CFG_SCREEN_HEIGHT: regs.screen_height = cfg_data_i[COORD_W-1:0];
          CFG_FG_COLOR:      regs.fg_color = cfg_data_i[COLOR_W-1:0];
          CFG_BG_COLOR:      regs.bg_color = cfg_data_i[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        case (kind_e'(item_ch.kind))
          KIND_DRAW:  paint_cell(item_ch.char_code);
          KIND_ERASE: step_back();
          KIND_NEWLINE: begin
            cur_y = line_below(cur_y);
            cur_x = '0;
          end
          default: font_rows[{item_ch.char_code, item_ch.font_row}] = item_ch.font_bits;
        endcase
      end
    end
    rows_pending = rows_due.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the glyph writer with font loads, draws, erases and newlines under
// several register settings, with random gaps and back-pressure, and leaves
// the row checking to tcgw_row_checker.
// ----------------------------------------------------------------------------
module tb;
  import tcgw_pkg::*;

  localparam int unsigned GH           = DEF_GLYPH_HEIGHT;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned mismatch_count;
  int unsigned rows_pending;
  int unsigned quiet_cycles = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_done = 0;
  bit          calm = 1'b0;

  // Which rows of each code have been loaded; only complete glyphs are drawn.
  bit [GH-1:0]       rows_loaded [256];
  logic [CODE_W-1:0] drawable [$];

  tcgw_in_if  item_ch ();
  tcgw_out_if row_ch ();

  text_console_glyph_writer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (item_ch),
    .out_ch     (row_ch)
  );

  tcgw_row_checker row_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .item_ch        (item_ch),
    .row_ch         (row_ch),
    .mismatch_count (mismatch_count),
    .rows_pending   (rows_pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (row_ch.valid && row_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Framebuffer side: random stalls, runs of steady acceptance, and one long
  // hold-off whenever the stimulus asks for it.
  initial begin : row_sink
    int unsigned span;
    row_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holds_done != holds_requested) begin
        row_ch.ready <= 1'b0;
        span = LONG_HOLD;
        holds_done++;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        row_ch.ready <= 1'b0;
        span = $urandom_range(1, 11);
      end else begin
        row_ch.ready <= 1'b1;
        span = $urandom_range(1, 40);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  task automatic send_item(input kind_e kind, input logic [CODE_W-1:0] code,
                           input logic [ROW_W-1:0] row, input logic [BITS_W-1:0] bits);
    bit was_full;
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    item_ch.valid     <= 1'b1;
    item_ch.kind      <= kind;
    item_ch.char_code <= code;
    item_ch.font_row  <= row;
    item_ch.font_bits <= bits;
    do @(posedge clk_i); while (!item_ch.ready);
    if (kind == KIND_LOAD) begin
      was_full = &rows_loaded[code];
      rows_loaded[code][row] = 1'b1;
      if (!was_full && &rows_loaded[code]) drawable.push_back(code);
    end
  endtask

  task automatic draw(input logic [CODE_W-1:0] code);
    send_item(KIND_DRAW, code, ROW_W'($urandom), BITS_W'($urandom));
  endtask

  task automatic erase();
    send_item(KIND_ERASE, CODE_W'($urandom), ROW_W'($urandom), BITS_W'($urandom));
  endtask

  task automatic newline();
    send_item(KIND_NEWLINE, CODE_W'($urandom), ROW_W'($urandom), BITS_W'($urandom));
  endtask

  task automatic load_glyph(input logic [CODE_W-1:0] code);
    for (int r = 0; r < GH; r++) begin
      send_item(KIND_LOAD, code, ROW_W'(r), BITS_W'($urandom));
    end
  endtask

  function automatic logic [CODE_W-1:0] any_drawable();
    return drawable[$urandom_range(0, drawable.size() - 1)];
  endfunction

  task automatic random_items(input int unsigned count);
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        draw(any_drawable());
      end else if (pick < 70) begin
        erase();
      end else if (pick < 80) begin
        newline();
      end else if (pick < 93) begin
        send_item(KIND_LOAD, CODE_W'($urandom), ROW_W'($urandom), BITS_W'($urandom));
      end else begin
        load_glyph(CODE_W'($urandom));
      end
    end
  endtask

  // Waits until every predicted row has been written, then gives trailing
  // loads and newlines time to leave the pipeline.
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(negedge clk_i); while (rows_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(CFG_FB_BASE, c.fb_base);
    write_reg(CFG_ROW_PITCH, CFG_DATA_W'(c.row_pitch));
    write_reg(CFG_BYTES_PER_PIX, CFG_DATA_W'(c.bytes_per_pixel));
    write_reg(CFG_SCREEN_WIDTH, CFG_DATA_W'(c.screen_width));
    write_reg(CFG_SCREEN_HEIGHT, CFG_DATA_W'(c.screen_height));
    write_reg(CFG_FG_COLOR, CFG_DATA_W'(c.fg_color));
    write_reg(CFG_BG_COLOR, CFG_DATA_W'(c.bg_color));
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_setting();
    cfg_t c;
    c.fb_base         = $urandom;
    c.row_pitch       = 16'($urandom_range(0, 8192));
    c.bytes_per_pixel = 3'($urandom_range(1, 4));
    c.screen_width    = COORD_W'($urandom_range(8, 1600));
    c.screen_height   = COORD_W'($urandom_range(16, 1200));
    c.fg_color        = COLOR_W'($urandom);
    c.bg_color        = COLOR_W'($urandom);
    return c;
  endfunction

  initial begin : stimulus
    cfg_t setting;
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_data          <= '0;
    item_ch.valid     <= 1'b0;
    item_ch.kind      <= KIND_DRAW;
    item_ch.char_code <= '0;
    item_ch.font_row  <= '0;
    item_ch.font_bits <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings. An erase at the origin does nothing and reads no glyph.
    erase();
    load_glyph(SPACE_CODE);
    load_glyph(8'h00);
    load_glyph(8'hFF);
    load_glyph(8'h55);
    load_glyph(8'hAA);
    draw(8'h00);
    draw(8'hFF);
    draw(8'h55);
    erase();
    newline();
    // From column 0 this goes back to the last cell of the line above, so the
    // next draw just fits and the one after it wraps.
    erase();
    draw(8'hAA);
    draw(SPACE_CODE);
    erase();
    erase();
    drain();

    program_regs(random_setting());
    random_items(25);
    drain();

    // Largest values in every field but the foreground colour; the row address overflows 32 bits.
    setting = '{fb_base: 32'hFFFF_FFFF, row_pitch: 16'hFFFF, bytes_per_pixel: 3'd7,
                screen_width: 12'hFFF, screen_height: 12'hFFF,
                fg_color: 24'h000000, bg_color: 24'hFFFFFF};
    program_regs(setting);
    holds_requested++;
    repeat (12) draw(any_drawable());
    random_items(12);
    drain();

    // Zero everywhere: a screen narrower than one cell wraps on every draw.
    setting = '{fb_base: 32'd0, row_pitch: 16'd0, bytes_per_pixel: 3'd0,
                screen_width: 12'd0, screen_height: 12'd0,
                fg_color: 24'h000000, bg_color: 24'h000000};
    program_regs(setting);
    draw(any_drawable());
    erase();
    erase();
    random_items(10);
    drain();

    // A width that is not a whole number of cells leaves the cursor inside
    // the first cell after an erase from column 0; the next erase goes to 0.
    setting = random_setting();
    setting.bytes_per_pixel = 3'd5;
    setting.screen_width    = 12'd13;
    setting.screen_height   = 12'd16;
    program_regs(setting);
    newline();
    erase();
    erase();
    random_items(10);
    drain();

    // Steady traffic to the end: move the cursor down and keep drawing.
    calm = 1'b1;
    setting = random_setting();
    setting.bytes_per_pixel = 3'd6;
    program_regs(setting);
    repeat (12) newline();
    random_items(12);
    drain();

    if (mismatch_count == 0 && rows_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tcgw_pkg.sv
rtl/core/tcgw_in_if.sv
rtl/core/tcgw_out_if.sv
rtl/core/tcgw_front.sv
rtl/core/tcgw_fifo.sv
rtl/core/tcgw_back.sv
rtl/core/text_console_glyph_writer.sv
verif/tcgw_row_checker.sv
verif/tb.sv
